/* hw/rtl/cscan_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscan_pkg
// shared types and constants of the c-scan seek scheduler
// ----------------------------------------------------------------------------
package cscan_pkg;

    localparam int MAX_REQUESTS_DEF = 32;
    localparam int CYL_BITS_DEF     = 16;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISK_SIZE = 2'd0,
        CFG_START_CYL = 2'd1,
        CFG_DIRECTION = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHL,
        CELL_SHL_WRAP,
        CELL_SHR
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_SWEEP_A,
        ST_JUMP,
        ST_SWEEP_B
    } sched_state_t;

endpackage

/* hw/rtl/cscan_disk_seek_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscan_disk_seek_scheduler
// c-scan seek scheduler built on a sorted chain of request cells
// ----------------------------------------------------------------------------
// a request is taken while not stalled and sorted in place by the chain;
// after the last request the start cylinder is emitted, the first sweep
// visits each stored request and serves or defers it, the end jump adds the
// end travel, and the second sweep serves each deferred request
// throughput: one request per cycle while loading, requests stalled while a
// schedule runs; reset sets disk size 2^CYL_BITS, start 0, upward sweep
// ----------------------------------------------------------------------------
module cscan_disk_seek_scheduler #(
    parameter int MAX_REQUESTS = cscan_pkg::MAX_REQUESTS_DEF,
    parameter int CYL_BITS     = cscan_pkg::CYL_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cscan_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [CYL_BITS:0]                 cfg_data,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [CYL_BITS-1:0]               cylinder,
    input  logic                              last,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [CYL_BITS-1:0]               served_cylinder,
    output logic [CYL_BITS+1:0]               seek_total,
    output logic                              final_res
);

    localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
    localparam int SEEK_W = CYL_BITS + 2;

    cscan_pkg::sched_state_t state_reg, state_next;

    logic [CYL_BITS-1:0] top_reg;
    logic [CYL_BITS-1:0] start_reg;
    logic                dir_reg;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    pops_reg, pops_next;
    logic [SEEK_W-1:0]   acc_reg, acc_next;
    logic [CYL_BITS-1:0] head_reg, head_next;
    logic [CYL_BITS-1:0] s_reg, s_next;

    logic                res_valid_reg, res_valid_next;
    logic [CYL_BITS-1:0] served_reg, served_next;
    logic [SEEK_W-1:0]   total_reg, total_next;
    logic                final_reg, final_next;

    cscan_pkg::cell_op_t cell_op;
    logic [CYL_BITS-1:0] cell_bcast;
    logic [CYL_BITS-1:0] first_val;
    logic [CYL_BITS-1:0] tail_val;

    logic                req_take;
    logic                can_emit;
    logic [CYL_BITS-1:0] pop_raw;
    logic [CYL_BITS-1:0] pop_v;
    logic [CYL_BITS-1:0] seek_step;
    logic [SEEK_W-1:0]   acc_emit;
    logic                emit_a;
    logic [CYL_BITS-1:0] s_clamp;
    logic [SEEK_W-1:0]   jump_acc;

    assign cfg_ready       = 1'b1;
    assign req_stall       = (state_reg != cscan_pkg::ST_LOAD);
    assign req_take        = req_valid && !req_stall;
    assign res_valid       = res_valid_reg;
    assign served_cylinder = served_reg;
    assign seek_total      = total_reg;
    assign final_res       = final_reg;

    assign can_emit = !res_valid_reg || !res_stall;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= '1;
            start_reg <= '0;
            dir_reg   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cscan_pkg::CFG_DISK_SIZE:
                begin
                    if (cfg_data == '0)
                    begin
                        top_reg <= '0;
                    end
                    else if (cfg_data[CYL_BITS])
                    begin
                        top_reg <= '1;
                    end
                    else
                    begin
                        top_reg <= cfg_data[CYL_BITS-1:0] - CYL_BITS'(1);
                    end
                end
                cscan_pkg::CFG_START_CYL: start_reg <= cfg_data[CYL_BITS-1:0];
                cscan_pkg::CFG_DIRECTION: dir_reg   <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    cscan_chain #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .CYL_BITS     (CYL_BITS)
    ) u_chain (
        .clk       (clk),
        .op        (cell_op),
        .bcast     (cell_bcast),
        .count     (count_reg),
        .first_val (first_val),
        .tail_val  (tail_val)
    );

    // datapath shared by both sweeps
    assign pop_raw   = dir_reg ? first_val : tail_val;
    assign pop_v     = (pop_raw > top_reg) ? top_reg : pop_raw;
    assign seek_step = (pop_v > head_reg) ? (pop_v - head_reg) : (head_reg - pop_v);
    assign acc_emit  = acc_reg + SEEK_W'(seek_step);
    assign emit_a    = dir_reg ? (pop_v >= s_reg) : (pop_v < s_reg);
    assign s_clamp   = (start_reg > top_reg) ? top_reg : start_reg;
    assign jump_acc  = acc_reg + SEEK_W'(top_reg)
                     + SEEK_W'(dir_reg ? (top_reg - head_reg) : head_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cscan_pkg::ST_LOAD:
            begin
                if (req_take && last)
                begin
                    state_next = cscan_pkg::ST_START;
                end
            end
            cscan_pkg::ST_START:
            begin
                if (can_emit)
                begin
                    state_next = (count_reg == '0) ? cscan_pkg::ST_JUMP
                                                   : cscan_pkg::ST_SWEEP_A;
                end
            end
            cscan_pkg::ST_SWEEP_A:
            begin
                if (can_emit && pops_reg == CNT_W'(1))
                begin
                    state_next = cscan_pkg::ST_JUMP;
                end
            end
            cscan_pkg::ST_JUMP:
            begin
                state_next = (count_reg == '0) ? cscan_pkg::ST_LOAD
                                               : cscan_pkg::ST_SWEEP_B;
            end
            cscan_pkg::ST_SWEEP_B:
            begin
                if (can_emit && count_reg == CNT_W'(1))
                begin
                    state_next = cscan_pkg::ST_LOAD;
                end
            end
            default: state_next = cscan_pkg::ST_LOAD;
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        count_next     = count_reg;
        pops_next      = pops_reg;
        acc_next       = acc_reg;
        head_next      = head_reg;
        s_next         = s_reg;
        res_valid_next = res_valid_reg && res_stall;
        served_next    = served_reg;
        total_next     = total_reg;
        final_next     = final_reg;
        cell_op        = cscan_pkg::CELL_HOLD;
        cell_bcast     = cylinder;

        unique case (state_reg)
            cscan_pkg::ST_LOAD:
            begin
                if (req_take && count_reg < CNT_W'(MAX_REQUESTS))
                begin
                    cell_op    = cscan_pkg::CELL_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            cscan_pkg::ST_START:
            begin
                if (can_emit)
                begin
                    s_next         = s_clamp;
                    head_next      = s_clamp;
                    acc_next       = '0;
                    pops_next      = count_reg;
                    served_next    = s_clamp;
                    total_next     = '0;
                    final_next     = 1'b0;
                    // held back until the end travel is added when nothing else is pending
                    res_valid_next = (count_reg != '0);
                end
            end
            cscan_pkg::ST_SWEEP_A:
            begin
                if (can_emit)
                begin
                    pops_next  = pops_reg - CNT_W'(1);
                    cell_bcast = pop_v;
                    if (emit_a)
                    begin
                        head_next      = pop_v;
                        acc_next       = acc_emit;
                        served_next    = pop_v;
                        total_next     = acc_emit;
                        final_next     = 1'b0;
                        res_valid_next = (count_reg != CNT_W'(1));
                        count_next     = count_reg - CNT_W'(1);
                        cell_op        = dir_reg ? cscan_pkg::CELL_SHL : cscan_pkg::CELL_HOLD;
                    end
                    else
                    begin
                        // deferred to the second sweep
                        cell_op = dir_reg ? cscan_pkg::CELL_SHL_WRAP : cscan_pkg::CELL_SHR;
                    end
                end
            end
            cscan_pkg::ST_JUMP:
            begin
                if (count_reg == '0)
                begin
                    total_next     = jump_acc;
                    final_next     = 1'b1;
                    res_valid_next = 1'b1;
                end
                else
                begin
                    acc_next  = jump_acc;
                    head_next = dir_reg ? '0 : top_reg;
                end
            end
            cscan_pkg::ST_SWEEP_B:
            begin
                if (can_emit)
                begin
                    head_next      = pop_v;
                    acc_next       = acc_emit;
                    served_next    = pop_v;
                    total_next     = acc_emit;
                    final_next     = (count_reg == CNT_W'(1));
                    res_valid_next = 1'b1;
                    count_next     = count_reg - CNT_W'(1);
                    cell_op        = dir_reg ? cscan_pkg::CELL_SHL : cscan_pkg::CELL_HOLD;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cscan_pkg::ST_LOAD;
            count_reg     <= '0;
            pops_reg      <= '0;
            acc_reg       <= '0;
            head_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pops_reg      <= pops_next;
            acc_reg       <= acc_next;
            head_reg      <= head_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        served_reg <= served_next;
        total_reg  <= total_next;
        final_reg  <= final_next;
    end

endmodule

/* hw/rtl/cscan_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscan_cell
// one slot of the sorted request chain
// ----------------------------------------------------------------------------
module cscan_cell #(
    parameter int CYL_BITS = cscan_pkg::CYL_BITS_DEF
) (
    input  logic                    clk,
    input  cscan_pkg::cell_op_t     op,
    input  logic [CYL_BITS-1:0]     bcast,
    input  logic                    valid,
    input  logic                    tail,
    input  logic [CYL_BITS-1:0]     left_val,
    input  logic                    left_gt,
    input  logic [CYL_BITS-1:0]     right_val,
    output logic [CYL_BITS-1:0]     val,
    output logic                    gt
);

    logic [CYL_BITS-1:0] val_reg;
    logic [CYL_BITS-1:0] val_next;

    assign val = val_reg;
    assign gt  = !valid || (val_reg > bcast);

    always_comb
    begin
        unique case (op)
            cscan_pkg::CELL_HOLD:     val_next = val_reg;
            cscan_pkg::CELL_INSERT:   val_next = gt ? (left_gt ? left_val : bcast) : val_reg;
            cscan_pkg::CELL_SHL:      val_next = right_val;
            cscan_pkg::CELL_SHL_WRAP: val_next = tail ? bcast : right_val;
            cscan_pkg::CELL_SHR:      val_next = left_val;
            default:                  val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

/* hw/rtl/cscan_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscan_chain
// row of cells keeping pending requests in ascending order
// ----------------------------------------------------------------------------
module cscan_chain #(
    parameter int MAX_REQUESTS = cscan_pkg::MAX_REQUESTS_DEF,
    parameter int CYL_BITS     = cscan_pkg::CYL_BITS_DEF,
    localparam int CNT_W       = $clog2(MAX_REQUESTS + 1)
) (
    input  logic                    clk,
    input  cscan_pkg::cell_op_t     op,
    input  logic [CYL_BITS-1:0]     bcast,
    input  logic [CNT_W-1:0]        count,
    output logic [CYL_BITS-1:0]     first_val,
    output logic [CYL_BITS-1:0]     tail_val
);

    logic [CYL_BITS-1:0] val  [MAX_REQUESTS];
    logic                gt   [MAX_REQUESTS];
    logic                tail [MAX_REQUESTS];

    for (genvar i = 0; i < MAX_REQUESTS; i++)
    begin : g_cell
        logic [CYL_BITS-1:0] left_val;
        logic                left_gt;
        logic [CYL_BITS-1:0] right_val;

        assign tail[i] = (count == CNT_W'(i + 1));

        if (i == 0)
        begin : g_first
            assign left_val = bcast;
            assign left_gt  = 1'b0;
        end
        else
        begin : g_mid
            assign left_val = val[i-1];
            assign left_gt  = gt[i-1];
        end

        if (i == MAX_REQUESTS - 1)
        begin : g_last
            assign right_val = bcast;
        end
        else
        begin : g_inner
            assign right_val = val[i+1];
        end

        cscan_cell #(
            .CYL_BITS (CYL_BITS)
        ) u_cell (
            .clk       (clk),
            .op        (op),
            .bcast     (bcast),
            .valid     (CNT_W'(i) < count),
            .tail      (tail[i]),
            .left_val  (left_val),
            .left_gt   (left_gt),
            .right_val (right_val),
            .val       (val[i]),
            .gt        (gt[i])
        );
    end

    assign first_val = val[0];

    always_comb
    begin
        tail_val = '0;
        for (int i = 0; i < MAX_REQUESTS; i++)
        begin
            if (tail[i])
            begin
                tail_val = tail_val | val[i];
            end
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the c-scan seek scheduler: drives request batches
// under a spread of disk sizes, start cylinders and sweep directions, predicts
// the service order and running seek totals, and checks every served result
// ----------------------------------------------------------------------------
module tb;

    import cscan_pkg::*;

    typedef struct packed {
        logic [15:0] cyl;
        logic [17:0] seek;
        logic        fin;
    } seek_result_t;

    class seek_scoreboard;
        logic [16:0]  disk_size;
        logic [15:0]  start_cyl;
        logic         sweep_up;
        logic [15:0]  slots [0:MAX_REQUESTS_DEF];
        int           held;
        logic [15:0]  head;
        logic [17:0]  acc;
        seek_result_t due_results [$];
        int           mismatches;

        function new();
            disk_size  = 17'h10000;
            start_cyl  = 16'd0;
            sweep_up   = 1'b1;
            held       = 0;
            head       = 16'd0;
            acc        = 18'd0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [16:0] val);
            case (idx)
                CFG_DISK_SIZE: disk_size = val;
                CFG_START_CYL: start_cyl = val[15:0];
                CFG_DIRECTION: sweep_up  = val[0];
                default: ;
            endcase
        endfunction

        function void insert_sorted(logic [15:0] v);
            int i;
            i = held;
            while (i > 0 && slots[i-1] > v)
            begin
                slots[i] = slots[i-1];
                i--;
            end
            slots[i] = v;
            held++;
        endfunction

        function void serve(logic [15:0] v);
            seek_result_t r;
            logic [15:0]  d;
            d = (v > head) ? v - head : head - v;
            acc = acc + 18'(d);
            head = v;
            r.cyl  = v;
            r.seek = acc;
            r.fin  = 1'b0;
            due_results.push_back(r);
        endfunction

        // one accepted request; the one marked last runs the whole sweep
        function void schedule_request(logic [15:0] cyl, logic is_last);
            logic [16:0]  span;
            logic [15:0]  top;
            logic [15:0]  s;
            int           n;
            int           pos;
            seek_result_t tail;
            if (held < MAX_REQUESTS_DEF)
                insert_sorted(cyl);
            if (!is_last)
                return;
            span = disk_size;
            if (span == 17'd0)
                span = 17'd1;
            if (span > 17'h10000)
                span = 17'h10000;
            top = 16'(span - 17'd1);
            for (int i = 0; i < held; i++)
                if (slots[i] > top)
                    slots[i] = top;
            s = (start_cyl > top) ? top : start_cyl;
            insert_sorted(s);
            n = held;
            pos = 0;
            while (pos < n && slots[pos] != s)
                pos++;
            head = s;
            acc = 18'd0;
            if (sweep_up)
            begin
                for (int i = pos; i < n; i++)
                    serve(slots[i]);
                acc = acc + 18'(top - head) + 18'(top);
                head = 16'd0;
                for (int i = 0; i < pos; i++)
                    serve(slots[i]);
            end
            else
            begin
                for (int i = pos; i >= 0; i--)
                    serve(slots[i]);
                acc = acc + 18'(head) + 18'(top);
                head = top;
                for (int i = n - 1; i > pos; i--)
                    serve(slots[i]);
            end
            // end travel and jump always land in the final total
            tail = due_results.pop_back();
            tail.seek = acc;
            tail.fin  = 1'b1;
            due_results.push_back(tail);
            held = 0;
        endfunction

        function void check_served(seek_result_t got);
            seek_result_t exp;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t unexpected result: cyl %0d seek %0d fin %0b",
                             $realtime, got.cyl, got.seek, got.fin);
                return;
            end
            exp = due_results.pop_front();
            if (got.cyl !== exp.cyl || got.seek !== exp.seek || got.fin !== exp.fin)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t mismatch: exp cyl %0d seek %0d fin %0b, got cyl %0d seek %0d fin %0b",
                             $realtime, exp.cyl, exp.seek, exp.fin,
                             got.cyl, got.seek, got.fin);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [16:0]          cfg_data;
    logic                 req_valid;
    logic                 req_stall;
    logic [15:0]          cylinder;
    logic                 last;
    logic                 res_valid;
    logic                 res_stall;
    logic [15:0]          served_cylinder;
    logic [17:0]          seek_total;
    logic                 final_res;

    logic                 idle_on;
    logic                 pressure_go;
    logic                 hold_off;

    seek_scoreboard sb = new();

    cscan_disk_seek_scheduler i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .cylinder        (cylinder),
        .last            (last),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .served_cylinder (served_cylinder),
        .seek_total      (seek_total),
        .final_res       (final_res)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("** cscan_disk_seek_scheduler: FAILED **");
        $finish;
    end

    // long receiver hold-off so that a schedule backs up into the request side
    initial
    begin
        hold_off = 1'b0;
        wait (pressure_go === 1'b1);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        seek_result_t got;
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_valid === 1'b1 && res_stall === 1'b0)
            begin
                got.cyl  = served_cylinder;
                got.seek = seek_total;
                got.fin  = final_res;
                sb.check_served(got);
            end
            res_stall <= hold_off || (idle_on && $urandom_range(99) < 7);
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(logic [16:0] ds, logic [15:0] st, logic dir);
        write_reg(CFG_DISK_SIZE, ds);
        write_reg(CFG_START_CYL, {1'b0, st});
        write_reg(CFG_DIRECTION, {16'd0, dir});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(logic [15:0] c, logic l);
        if (idle_on && $urandom_range(99) < 7)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        req_valid <= 1'b1;
        cylinder  <= c;
        last      <= l;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        sb.schedule_request(c, l);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic int span_of(logic [16:0] ds);
        if (ds == 17'd0)
            return 1;
        if (ds > 17'h10000)
            return 65536;
        return int'(ds);
    endfunction

    // batch of random requests biased towards the disk, the start and repeats
    task automatic random_batch(int n_req);
        int          span;
        int          r;
        logic [15:0] c;
        logic [15:0] prev;
        span = span_of(sb.disk_size);
        prev = sb.start_cyl;
        for (int i = 0; i < n_req; i++)
        begin
            r = $urandom_range(99);
            if (r < 60)
                c = 16'($urandom_range(span - 1, 0));
            else if (r < 75)
                c = sb.start_cyl;
            else if (r < 85)
                c = prev;
            else
                c = 16'($urandom);
            prev = c;
            send_request(c, i == n_req - 1);
        end
    endtask

    initial
    begin
        int          sent;
        int          batch;
        int          n_req;
        int          span;
        int          r;
        logic [16:0] ds;
        logic [15:0] st;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_DISK_SIZE;
        cfg_data    = 17'd0;
        req_valid   = 1'b0;
        cylinder    = 16'd0;
        last        = 1'b0;
        idle_on     = 1'b1;
        pressure_go = 1'b0;
        sent        = 0;
        batch       = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: full disk, start at zero, upward sweep
        send_request(16'hFFFF, 1'b0);
        send_request(16'd100, 1'b0);
        send_request(16'd0, 1'b1);
        drain();

        // zero disk size behaves as a single cylinder
        configure(17'd0, 16'd5, 1'b0);
        send_request(16'd7, 1'b1);
        drain();

        // oversize disk clamps to full width, start at the top
        configure(17'h1FFFF, 16'hFFFF, 1'b1);
        send_request(16'd0, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h8000, 1'b1);
        drain();

        // downward sweep with a duplicate of the start and a clamped request
        configure(17'd1000, 16'd500, 1'b0);
        send_request(16'd500, 1'b0);
        send_request(16'd200, 1'b0);
        send_request(16'd900, 1'b0);
        send_request(16'd1200, 1'b0);
        send_request(16'd0, 1'b1);
        drain();

        configure(17'd2, 16'd1, 1'b1);
        send_request(16'd1, 1'b1);
        drain();

        while (sent < 210)
        begin
            batch++;
            if (batch == 4)
                pressure_go = 1'b1;
            if (batch == 9)
                idle_on = 1'b0;
            if (batch == 15)
                idle_on = 1'b1;
            if ((batch < 4 || batch > 8) && $urandom_range(1) == 1)
            begin
                drain();
                r = $urandom_range(9);
                if (r < 3)
                    ds = 17'h10000;
                else if (r < 6)
                    ds = 17'($urandom_range(64, 1));
                else if (r < 9)
                    ds = 17'($urandom_range(65536, 1));
                else
                    ds = 17'($urandom_range(131071, 0));
                span = span_of(ds);
                if ($urandom_range(9) < 7)
                    st = 16'($urandom_range(span - 1, 0));
                else
                    st = 16'($urandom);
                configure(ds, st, 1'($urandom_range(1)));
            end
            if ($urandom_range(5) == 0)
                n_req = $urandom_range(40, 33);
            else
                n_req = $urandom_range(24, 1);
            random_batch(n_req);
            sent += n_req;
        end
        drain();

        if (sb.mismatches == 0 && sb.due_results.size() == 0)
            $display("** cscan_disk_seek_scheduler: PASSED **");
        else
            $display("** cscan_disk_seek_scheduler: FAILED **");
        $finish;
    end

endmodule
